// ----- hdl/bkr_pkg.sv -----
// ============================================================================
// bkr_pkg - banked key remapper shared definitions
// Beat formats, result and request codes and fixed sizes of the remapper.
// ============================================================================
package bkr_pkg;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int SC_W     = 6;
  localparam int IDX_W    = 8;
  localparam int KC_W     = 10;
  localparam int BANK_W   = 2;
  localparam int RES_W    = 3;
  localparam int KCNT_W   = 6;

  // Number of keymap banks.
  localparam int BANKS = 3;

  // Highest legal bank number.
  localparam logic [BANK_W-1:0] BANK_MAX = 2'd2;

  // Key count after reset.
  localparam logic [KCNT_W-1:0] KEYS_USED_RST = 6'd32;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BANK  = 2'd2;

  // Result codes.
  localparam logic [RES_W-1:0] RES_KEY   = 3'd0;
  localparam logic [RES_W-1:0] RES_SCAN  = 3'd1;
  localparam logic [RES_W-1:0] RES_WRITE = 3'd2;
  localparam logic [RES_W-1:0] RES_BANK  = 3'd3;
  localparam logic [RES_W-1:0] RES_ERR   = 3'd4;

  // Input beat.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SC_W-1:0]   key_scancode;
    logic              key_pressed;
    logic [IDX_W-1:0]  map_index;
    logic [KC_W-1:0]   map_keycode;
    logic [BANK_W-1:0] bank_select;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [RES_W-1:0] event_res;
    logic [KC_W-1:0]  out_keycode;
    logic             out_value;
    logic [SC_W-1:0]  out_scancode;
    logic             old_still_mapped;
    logic             last;
  } out_beat_t;

endpackage

// ----- hdl/banked_key_remapper.sv -----
// ============================================================================
// banked_key_remapper - macro key remapper with three keymap banks
// Looks up key events in the current bank, rewrites keymap entries and
// switches banks with releases for keys that change meaning.
// ============================================================================
// One request is handled at a time; in_stall is high from acceptance until
// the final result beat has been loaded into the output register, which
// then waits for the consumer while the next request is taken. All work goes
// through the keymap memory, which has registered reads on two
// ports. A key event is dispatched, read and reported; a table write reads the
// old entry, writes the new one and searches the table (one memory read per
// entry when searching for the old keycode); a bank select reads and compares
// both banks key by key, alternating a read state and a compare state. Errors
// are reported from the error state after dispatch. The keymap reads as zero
// after reset through per-entry valid flags, so no clearing pass is needed.
module banked_key_remapper
  import bkr_pkg::*;
#(
  parameter int MAX_KEYS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_beat,
  input  logic              cfg_wr_en,
  input  logic [KCNT_W-1:0] cfg_wr_data
);

  localparam int TOTAL = BANKS * MAX_KEYS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_KEY   = 10'b0000000100,
    S_WOLD  = 10'b0000001000,
    S_WSCAN = 10'b0000010000,
    S_WDONE = 10'b0000100000,
    S_BRD   = 10'b0001000000,
    S_BCMP  = 10'b0010000000,
    S_BDONE = 10'b0100000000,
    S_ERR   = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  in_beat_t            item_r;
  logic [KCNT_W-1:0]   keys_used_r;
  logic [BANK_W-1:0]   current_bank_r, bank_nxt;
  logic [MAX_KEYS-1:0] key_down_r, key_down_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                chk_r, chk_nxt;
  logic                still_r, still_nxt;
  logic [KC_W-1:0]     old_r, old_nxt;
  logic                out_valid_r;
  out_beat_t           out_beat_r;

  // Keymap memory with per-entry valid flags.
  logic [KC_W-1:0]     keymap_mem [TOTAL];
  logic [TOTAL-1:0]    map_vld_r;
  logic [KC_W-1:0]     rda_mem_r, rdb_mem_r;
  logic                rda_vld_r, rdb_vld_r;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rda_addr8, rdb_addr8;
  logic [AW-1:0]       rda_addr, rdb_addr, wr_addr;
  logic [KC_W-1:0]     rda_code, rdb_code;

  logic [KCNT_W-1:0]   eff_n;
  logic [IDX_W-1:0]    total;
  logic [IDX_W-1:0]    cur_base, new_base;
  logic                out_free;
  logic                emit;
  out_beat_t           emit_beat;
  logic                need_emit;

  // Base of a bank in the linear table: bank * n.
  function automatic logic [IDX_W-1:0] bank_base(input logic [BANK_W-1:0] b,
                                                 input logic [KCNT_W-1:0] n);
    logic [IDX_W-1:0] n_ext;
    n_ext = IDX_W'(n);
    return (b[1] ? (n_ext << 1) : '0) + (b[0] ? n_ext : '0);
  endfunction

  // Effective key count and table size.
  assign eff_n    = (keys_used_r > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : keys_used_r;
  assign total    = bank_base(BANK_MAX, eff_n) + IDX_W'(eff_n);
  assign cur_base = bank_base(current_bank_r, eff_n);
  assign new_base = bank_base(item_r.bank_select, eff_n);

  assign rda_addr = rda_addr8[AW-1:0];
  assign rdb_addr = rdb_addr8[AW-1:0];
  assign wr_addr  = item_r.map_index[AW-1:0];
  assign rda_code = rda_vld_r ? rda_mem_r : '0;
  assign rdb_code = rdb_vld_r ? rdb_mem_r : '0;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Request sequencer.
  always_comb begin
    state_nxt    = state_r;
    bank_nxt     = current_bank_r;
    key_down_nxt = key_down_r;
    cnt_nxt      = cnt_r;
    chk_nxt      = 1'b0;
    still_nxt    = still_r;
    old_nxt      = old_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    rda_addr8    = '0;
    rdb_addr8    = '0;
    emit         = 1'b0;
    emit_beat    = '0;
    need_emit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (item_r.kind)
          KIND_KEY: begin
            if (item_r.key_scancode >= eff_n) begin
              state_nxt = S_ERR;
            end else begin
              rd_en     = 1'b1;
              rda_addr8 = cur_base + IDX_W'(item_r.key_scancode);
              state_nxt = S_KEY;
            end
          end
          KIND_WRITE: begin
            if (item_r.map_index >= total) begin
              state_nxt = S_ERR;
            end else begin
              rd_en     = 1'b1;
              rda_addr8 = item_r.map_index;
              state_nxt = S_WOLD;
            end
          end
          KIND_BANK: begin
            if (item_r.bank_select > BANK_MAX) begin
              state_nxt = S_ERR;
            end else begin
              cnt_nxt   = '0;
              state_nxt = S_BRD;
            end
          end
          default: begin
            state_nxt = S_ERR;
          end
        endcase
      end
      // Report a mapped key, or a fresh press of an unmapped one.
      S_KEY: begin
        emit_beat.last = 1'b1;
        if (rda_code != '0) begin
          need_emit             = 1'b1;
          emit_beat.event_res   = RES_KEY;
          emit_beat.out_keycode = rda_code;
          emit_beat.out_value   = item_r.key_pressed;
        end else if (!key_down_r[item_r.key_scancode[KW-1:0]] && item_r.key_pressed) begin
          need_emit              = 1'b1;
          emit_beat.event_res    = RES_SCAN;
          emit_beat.out_scancode = item_r.key_scancode;
        end
        if (!need_emit || out_free) begin
          emit = need_emit;
          key_down_nxt[item_r.key_scancode[KW-1:0]] = item_r.key_pressed;
          state_nxt = S_IDLE;
        end
      end
      // Old entry has arrived; replace it and start the search.
      S_WOLD: begin
        old_nxt   = rda_code;
        wr_en     = 1'b1;
        cnt_nxt   = '0;
        still_nxt = 1'b0;
        state_nxt = S_WSCAN;
      end
      // Search the whole table for the old keycode, one entry a cycle.
      S_WSCAN: begin
        if (chk_r && (rda_code == old_r)) begin
          still_nxt = 1'b1;
        end
        if (cnt_r < total) begin
          rd_en     = 1'b1;
          rda_addr8 = cnt_r;
          cnt_nxt   = cnt_r + 1'b1;
          chk_nxt   = 1'b1;
        end else if (!chk_r) begin
          state_nxt = S_WDONE;
        end
      end
      S_WDONE: begin
        if (out_free) begin
          emit                       = 1'b1;
          emit_beat.event_res        = RES_WRITE;
          emit_beat.out_keycode      = old_r;
          emit_beat.old_still_mapped = still_r;
          emit_beat.last             = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      // Fetch the same key from both banks.
      S_BRD: begin
        if (cnt_r < IDX_W'(eff_n)) begin
          rd_en     = 1'b1;
          rda_addr8 = cur_base + cnt_r;
          rdb_addr8 = new_base + cnt_r;
          state_nxt = S_BCMP;
        end else begin
          state_nxt = S_BDONE;
        end
      end
      // Release a mapped key whose meaning changes.
      S_BCMP: begin
        emit_beat.event_res   = RES_KEY;
        emit_beat.out_keycode = rda_code;
        need_emit = (rda_code != rdb_code) && (rda_code != '0);
        if (!need_emit || out_free) begin
          emit = need_emit;
          if (rda_code != rdb_code) begin
            key_down_nxt[cnt_r[KW-1:0]] = 1'b0;
          end
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_BRD;
        end
      end
      S_BDONE: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_beat.event_res = RES_BANK;
          emit_beat.last      = 1'b1;
          bank_nxt            = item_r.bank_select;
          state_nxt           = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_beat.event_res = RES_ERR;
          emit_beat.last      = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      keys_used_r    <= KEYS_USED_RST;
      current_bank_r <= '0;
      key_down_r     <= '0;
      map_vld_r      <= '0;
      out_valid_r    <= 1'b0;
      chk_r          <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      current_bank_r <= bank_nxt;
      key_down_r     <= key_down_nxt;
      chk_r          <= chk_nxt;
      if (cfg_wr_en) begin
        keys_used_r <= cfg_wr_data;
      end
      if (wr_en) begin
        map_vld_r[wr_addr] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_beat;
    end
    if (emit) begin
      out_beat_r <= emit_beat;
    end
    cnt_r   <= cnt_nxt;
    still_r <= still_nxt;
    old_r   <= old_nxt;
  end

  // Keymap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keymap_mem[wr_addr] <= item_r.map_keycode;
    end
    if (rd_en) begin
      rda_mem_r <= keymap_mem[rda_addr];
      rdb_mem_r <= keymap_mem[rdb_addr];
      rda_vld_r <= map_vld_r[rda_addr];
      rdb_vld_r <= map_vld_r[rdb_addr];
    end
  end

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (!rst_n) emit |-> out_free)
    else $error("result loaded over a waiting beat");

  // An accepted request is dispatched in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISP))
    else $error("accepted request not dispatched");

  // The keymap is only written right after the old entry is read.
  assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> $past(rd_en))
    else $error("keymap written without a prior read");

  // The selected bank is always a legal one.
  assert property (@(posedge clk) disable iff (!rst_n) current_bank_r <= BANK_MAX)
    else $error("illegal current bank");

  // The table search never runs past the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WSCAN) |-> (cnt_r <= total))
    else $error("table search overran");

endmodule

// ----- test/banked_key_remapper_test.sv -----
// ============================================================================
// banked_key_remapper_test - self-checking bench for the banked key remapper
// Drives key events, keymap writes and bank selects under several key counts
// and predicts every result beat from a shadow keymap, down bits and bank.
// ============================================================================
module banked_key_remapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bkr_pkg::*;

  localparam int MAX_KEYS      = 32;
  localparam int SETTLE_CYCLES = 120;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 600000;

  // Request kind and bank number that the block must reject.
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
  localparam logic [BANK_W-1:0] BANK_BAD = 2'd3;

  // Shadow of the remapper state and the queue of result beats still owed.
  class remap_scoreboard;
    logic [KC_W-1:0]   keymap [BANKS*MAX_KEYS];
    bit                key_down [MAX_KEYS];
    logic [BANK_W-1:0] bank;
    logic [KCNT_W-1:0] keys_used;
    out_beat_t         pending_reports [$];
    int                mismatches;
    int                beat_no;

    function new();
      foreach (keymap[i]) keymap[i] = '0;
      foreach (key_down[i]) key_down[i] = 1'b0;
      bank = '0;
      keys_used = KEYS_USED_RST;
      mismatches = 0;
      beat_no = 0;
    endfunction

    task log_mismatch(input string what);
      $display("[%0t] beat %0d: %s", $realtime, beat_no, what);
      mismatches++;
    endtask

    function void expect_beat(input logic [RES_W-1:0] res, input logic [KC_W-1:0] code,
                              input logic value, input logic [SC_W-1:0] scan,
                              input logic still, input logic is_last);
      out_beat_t e;
      e.event_res        = res;
      e.out_keycode      = code;
      e.out_value        = value;
      e.out_scancode     = scan;
      e.old_still_mapped = still;
      e.last             = is_last;
      pending_reports.push_back(e);
    endfunction

    // Updates the shadow state for one accepted request and queues the
    // result beats it causes. Returns how many were queued.
    function int predict_request(input in_beat_t b);
      int n;
      int total;
      int queued_prior;
      logic [KC_W-1:0] code;
      logic [KC_W-1:0] old_code;
      logic [KC_W-1:0] ko;
      logic [KC_W-1:0] kn;
      logic still;
      queued_prior = pending_reports.size();
      n = (keys_used > MAX_KEYS) ? MAX_KEYS : int'(keys_used);
      total = BANKS * n;
      case (b.kind)
        KIND_KEY: begin
          if (b.key_scancode >= n) begin
            expect_beat(RES_ERR, '0, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            code = keymap[int'(bank) * n + int'(b.key_scancode)];
            if (code != '0) begin
              expect_beat(RES_KEY, code, b.key_pressed, '0, 1'b0, 1'b1);
            end else if (!key_down[b.key_scancode] && b.key_pressed) begin
              expect_beat(RES_SCAN, '0, 1'b0, b.key_scancode, 1'b0, 1'b1);
            end
            // The down bit follows the event even when nothing is reported.
            key_down[b.key_scancode] = b.key_pressed;
          end
        end
        KIND_WRITE: begin
          if (b.map_index >= total) begin
            expect_beat(RES_ERR, '0, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            old_code = keymap[b.map_index];
            keymap[b.map_index] = b.map_keycode;
            still = 1'b0;
            for (int i = 0; i < total; i++) begin
              if (keymap[i] == old_code) still = 1'b1;
            end
            expect_beat(RES_WRITE, old_code, 1'b0, '0, still, 1'b1);
          end
        end
        KIND_BANK: begin
          if (b.bank_select > BANK_MAX) begin
            expect_beat(RES_ERR, '0, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            // Release every mapped key whose meaning changes with the bank.
            for (int sc = 0; sc < n; sc++) begin
              ko = keymap[int'(bank) * n + sc];
              kn = keymap[int'(b.bank_select) * n + sc];
              if (ko != kn) begin
                if (ko != '0) expect_beat(RES_KEY, ko, 1'b0, '0, 1'b0, 1'b0);
                key_down[sc] = 1'b0;
              end
            end
            bank = b.bank_select;
            expect_beat(RES_BANK, '0, 1'b0, '0, 1'b0, 1'b1);
          end
        end
        default: begin
          expect_beat(RES_ERR, '0, 1'b0, '0, 1'b0, 1'b1);
        end
      endcase
      return pending_reports.size() - queued_prior;
    endfunction

    // Compares one accepted result beat with the oldest one owed.
    task check_report(input out_beat_t got);
      out_beat_t want;
      beat_no++;
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat %h", got));
      end else begin
        want = pending_reports.pop_front();
        if (got.event_res !== want.event_res)
          log_mismatch($sformatf("event_res %0d, expected %0d", got.event_res,
                                 want.event_res));
        if (got.out_keycode !== want.out_keycode)
          log_mismatch($sformatf("out_keycode %0d, expected %0d", got.out_keycode,
                                 want.out_keycode));
        if (got.out_value !== want.out_value)
          log_mismatch($sformatf("out_value %0d, expected %0d", got.out_value,
                                 want.out_value));
        if (got.out_scancode !== want.out_scancode)
          log_mismatch($sformatf("out_scancode %0d, expected %0d", got.out_scancode,
                                 want.out_scancode));
        if (got.old_still_mapped !== want.old_still_mapped)
          log_mismatch($sformatf("old_still_mapped %0d, expected %0d",
                                 got.old_still_mapped, want.old_still_mapped));
        if (got.last !== want.last)
          log_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
      end
    endtask
  endclass

  logic              clk = 1'b1;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_beat_t          in_beat = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_beat;
  logic              cfg_wr_en = 1'b0;
  logic [KCNT_W-1:0] cfg_wr_data = '0;

  remap_scoreboard board;
  bit              sender_gaps = 1'b0;
  bit              receiver_stalls = 1'b0;
  bit              hold_request = 1'b0;
  int              hold_left = 0;
  int              stall_left = 0;
  int              cycle_count = 0;

  banked_key_remapper #(
    .MAX_KEYS(MAX_KEYS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b0;
    #5 clk = 1'b1;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: a long hold-off on request, otherwise random stall bursts.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Check each result beat as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_report(out_beat);
  end

  function automatic in_beat_t make_request(input logic [KIND_W-1:0] kind,
                                            input logic [SC_W-1:0] scan,
                                            input logic pressed,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [KC_W-1:0] code,
                                            input logic [BANK_W-1:0] sel);
    in_beat_t b;
    b.kind         = kind;
    b.key_scancode = scan;
    b.key_pressed  = pressed;
    b.map_index    = idx;
    b.map_keycode  = code;
    b.bank_select  = sel;
    return b;
  endfunction

  // Mostly well-formed requests for n keys per bank, with some out of range.
  // Keycodes come mostly from a small pool so that old codes stay mapped.
  function automatic in_beat_t random_request(input int n);
    in_beat_t b;
    int pick;
    int total;
    b = make_request(KIND_W'($urandom_range(0, 3)), SC_W'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 255)),
                     KC_W'($urandom_range(0, 1023)), BANK_W'($urandom_range(0, 3)));
    total = BANKS * n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b.kind = KIND_KEY;
      if (n > 0 && $urandom_range(0, 9) != 0)
        b.key_scancode = SC_W'($urandom_range(0, n - 1));
    end else if (pick < 75) begin
      b.kind = KIND_WRITE;
      if (total > 0 && $urandom_range(0, 9) != 0)
        b.map_index = IDX_W'($urandom_range(0, total - 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) b.map_keycode = '0;
      else if (pick < 75) b.map_keycode = KC_W'($urandom_range(1, 8));
      else if (pick < 95) b.map_keycode = KC_W'($urandom_range(0, 767));
    end else if (pick < 93) begin
      b.kind = KIND_BANK;
      b.bank_select = ($urandom_range(0, 9) == 0) ? BANK_BAD
                                                  : BANK_W'($urandom_range(0, 2));
    end else begin
      b.kind = KIND_BAD;
    end
    return b;
  endfunction

  // Offers one request beat at a falling edge and holds it until taken.
  // Valid stays high afterwards; gaps and pauses lower it.
  task automatic send_request(input in_beat_t b, output int produced);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_beat = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = board.predict_request(b);
    @(negedge clk);
  endtask

  // Stops sending, waits for every owed result beat, then lets the block
  // finish any request that produces no result.
  task automatic drain_and_settle();
    int waited;
    in_valid = 1'b0;
    waited = 0;
    while (board.pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (board.pending_reports.size() != 0) begin
      board.log_mismatch($sformatf("%0d result beats never arrived",
                                   board.pending_reports.size()));
      board.pending_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_keys_used(input logic [KCNT_W-1:0] value);
    drain_and_settle();
    while (in_stall) @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.keys_used = value;
  endtask

  initial begin
    int produced;
    int sent;
    int eff;
    logic [KCNT_W-1:0] counts [6];
    int quotas [6];
    counts = '{6'd1, 6'd63, 6'd0, 6'd5, 6'd17, 6'd32};
    quotas = '{40, 70, 15, 50, 60, 55};
    board = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;

    // Directed part at the reset key count of 32.
    // Unmapped key: scan report on first press only, silent release.
    send_request(make_request(KIND_KEY, 6'd3, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_KEY, 6'd3, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_KEY, 6'd3, 1'b0, 8'd0, 10'd0, 2'd0), produced);
    // Scancodes beyond the key count, then the highest valid one.
    send_request(make_request(KIND_KEY, 6'd63, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_KEY, 6'd32, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_KEY, 6'd31, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    // Table writes: old code still mapped or gone, wide keycode, both ends.
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd0, 10'd767, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd1, 10'd767, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd0, 10'd5, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd1, 10'd1023, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd95, 10'd1, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd96, 10'd9, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd255, 10'd9, 2'd0), produced);
    // Mapped keys report their keycode with the pressed value.
    send_request(make_request(KIND_KEY, 6'd0, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_KEY, 6'd0, 1'b0, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_KEY, 6'd1, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    // Bank 1: key 1 keeps its code, key 0 changes.
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd33, 10'd1023, 2'd0), produced);
    send_request(make_request(KIND_WRITE, 6'd0, 1'b0, 8'd32, 10'd6, 2'd0), produced);
    // Bank selects: rejected, switching, same bank, and back to bank 0.
    send_request(make_request(KIND_BANK, 6'd0, 1'b0, 8'd0, 10'd0, BANK_BAD), produced);
    send_request(make_request(KIND_BANK, 6'd0, 1'b0, 8'd0, 10'd0, 2'd1), produced);
    send_request(make_request(KIND_KEY, 6'd0, 1'b1, 8'd0, 10'd0, 2'd0), produced);
    send_request(make_request(KIND_BANK, 6'd0, 1'b0, 8'd0, 10'd0, 2'd1), produced);
    send_request(make_request(KIND_BANK, 6'd0, 1'b0, 8'd0, 10'd0, 2'd2), produced);
    send_request(make_request(KIND_BANK, 6'd0, 1'b0, 8'd0, 10'd0, 2'd0), produced);
    // Invalid request kind.
    send_request(make_request(KIND_BAD, 6'd63, 1'b1, 8'd255, 10'd1023, 2'd3), produced);

    // Random part, one phase per key count; the last phase runs without idling.
    for (int phase = 0; phase < 6; phase++) begin
      write_keys_used(counts[phase]);
      eff = (counts[phase] > MAX_KEYS) ? MAX_KEYS : int'(counts[phase]);
      // The phase starts from a drained block; in this one the result side
      // also holds off long enough for the block to back up.
      if (phase == 1) begin
        @(posedge clk);
        hold_request = 1'b1;
        @(negedge clk);
      end
      sent = 0;
      while (sent < quotas[phase]) begin
        if (sent % 30 == 0) begin
          sender_gaps = (phase != 5) && ($urandom_range(0, 2) != 0);
          receiver_stalls = (phase != 5) && ($urandom_range(0, 2) != 0);
        end
        send_request(random_request(eff), produced);
        sent++;
      end
    end

    drain_and_settle();
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
